@@ design/mnpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parameter number parser package
// Shared controller codes, operation codes and the transaction structs that
// pass between the stages of the parser.
// ----------------------------------------------------------------------------
package mnpp_pkg;

  // Controller numbers that the parser reacts to.
  localparam logic [6:0] CC_NRPN_LSB = 7'd98;
  localparam logic [6:0] CC_NRPN_MSB = 7'd99;
  localparam logic [6:0] CC_RPN_LSB  = 7'd100;
  localparam logic [6:0] CC_RPN_MSB  = 7'd101;
  localparam logic [6:0] CC_DATA_LSB = 7'd38;
  localparam logic [6:0] CC_DATA_MSB = 7'd6;

  typedef enum logic [0:0] {
    OP_FEED  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // One accepted input transaction.
  typedef struct packed {
    op_t        op;
    logic       is_cc;
    logic [3:0] channel;
    logic [6:0] controller;
    logic [6:0] data;
  } msg_t;

  // One completed parameter message.
  typedef struct packed {
    logic [3:0]  channel;
    logic [13:0] number;
    logic [13:0] value;
    logic        registered;
    logic        fourteen_bit;
  } res_t;

endpackage

@@ design/mnpp_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register stage
// Captures one input transaction and holds it until the parser stage takes it.
// ----------------------------------------------------------------------------
module mnpp_in_stage import mnpp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic       in_is_control_change,
  input  logic [3:0] in_midi_channel,
  input  logic [6:0] in_controller,
  input  logic [6:0] in_data_value,
  input  logic       advance,
  output logic       valid,
  output msg_t       msg
);

  logic valid_r;
  logic valid_nxt;
  msg_t msg_r;
  logic accept;

  assign in_ready = !valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg_r.op         <= op_t'(in_operation);
      msg_r.is_cc      <= in_is_control_change;
      msg_r.channel    <= in_midi_channel;
      msg_r.controller <= in_controller;
      msg_r.data       <= in_data_value;
    end
  end

  assign valid = valid_r;
  assign msg   = msg_r;

endmodule

@@ design/mnpp_chan_state.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-channel parser state
// Holds the parameter number and value bytes of every channel, applies one
// message per cycle while fire is high and forms the result on data entry.
// ----------------------------------------------------------------------------
module mnpp_chan_state import mnpp_pkg::*; #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  msg_t msg,
  output logic emit,
  output res_t res
);

  localparam int         IDX_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [4:0] CH_LIMIT = 5'(CHANNEL_COUNT);

  logic [CHANNEL_COUNT-1:0] hi_known_r;
  logic [CHANNEL_COUNT-1:0] lo_known_r;
  logic [CHANNEL_COUNT-1:0] reg_mark_r;
  logic [CHANNEL_COUNT-1:0] val_known_r;
  logic [6:0]               hi_byte_r  [CHANNEL_COUNT];
  logic [6:0]               lo_byte_r  [CHANNEL_COUNT];
  logic [6:0]               val_byte_r [CHANNEL_COUNT];

  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             act;
  logic             clear_all;
  logic             set_num;
  logic             num_high;
  logic             num_reg;
  logic             set_val;
  logic             data_entry;

  assign idx       = msg.channel[IDX_W-1:0];
  assign in_range  = {1'b0, msg.channel} < CH_LIMIT;
  assign clear_all = fire && (msg.op == OP_CLEAR);
  assign act       = fire && (msg.op == OP_FEED) && msg.is_cc && in_range;

  always_comb begin
    set_num    = 1'b0;
    num_high   = 1'b0;
    num_reg    = 1'b0;
    set_val    = 1'b0;
    data_entry = 1'b0;
    case (msg.controller)
      CC_NRPN_LSB: begin
        set_num = 1'b1;
      end
      CC_NRPN_MSB: begin
        set_num  = 1'b1;
        num_high = 1'b1;
      end
      CC_RPN_LSB: begin
        set_num = 1'b1;
        num_reg = 1'b1;
      end
      CC_RPN_MSB: begin
        set_num  = 1'b1;
        num_high = 1'b1;
        num_reg  = 1'b1;
      end
      CC_DATA_LSB: begin
        set_val = 1'b1;
      end
      CC_DATA_MSB: begin
        data_entry = 1'b1;
      end
      default: begin
        set_num = 1'b0;
      end
    endcase
  end

  // A result needs both number bytes of the channel.
  assign emit = act && data_entry && hi_known_r[idx] && lo_known_r[idx];

  always_comb begin
    res.channel      = msg.channel;
    res.number       = {hi_byte_r[idx], lo_byte_r[idx]};
    res.registered   = reg_mark_r[idx];
    res.fourteen_bit = val_known_r[idx];
    if (val_known_r[idx]) begin
      res.value = {msg.data, val_byte_r[idx]};
    end else begin
      res.value = {7'd0, msg.data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      hi_known_r  <= '0;
      lo_known_r  <= '0;
      reg_mark_r  <= '0;
      val_known_r <= '0;
    end else if (act) begin
      if (set_num) begin
        val_known_r[idx] <= 1'b0;
        reg_mark_r[idx]  <= num_reg;
        if (num_high) begin
          hi_known_r[idx] <= 1'b1;
        end else begin
          lo_known_r[idx] <= 1'b1;
        end
      end
      if (set_val) begin
        val_known_r[idx] <= 1'b1;
      end
    end
  end

  // Byte stores are only read while their known flag is set.
  always_ff @(posedge clk) begin
    if (act && set_num && num_high) begin
      hi_byte_r[idx] <= msg.data;
    end
    if (act && set_num && !num_high) begin
      lo_byte_r[idx] <= msg.data;
    end
    if (act && set_val) begin
      val_byte_r[idx] <= msg.data;
    end
  end

endmodule

@@ design/mnpp_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register stage
// Holds one completed parameter message until the downstream side takes it.
// ----------------------------------------------------------------------------
module mnpp_out_stage import mnpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        emit,
  input  res_t        res,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel,
  output logic [13:0] out_parameter_number,
  output logic [13:0] out_parameter_value,
  output logic        out_is_registered,
  output logic        out_is_fourteen_bit
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // The parser stage may move on when this register is empty or being emptied.
  assign advance = !valid_r || out_ready;

  always_comb begin
    if (fire) begin
      valid_nxt = emit;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_r <= res;
    end
  end

  assign out_valid            = valid_r;
  assign out_channel          = res_r.channel;
  assign out_parameter_number = res_r.number;
  assign out_parameter_value  = res_r.value;
  assign out_is_registered    = res_r.registered;
  assign out_is_fourteen_bit  = res_r.fourteen_bit;

endmodule

@@ design/midi_parameter_number_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parameter number parser
// Assembles registered and non-registered parameter number messages from a
// stream of MIDI control changes, with an independent parser per channel.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   operation, control-change flag, channel,
//                                   controller, data byte
//   result    out_valid / out_ready channel, parameter number and value,
//                                   registered and 14-bit flags
//
// Each transaction is held in the input register and is applied to the
// per-channel state on the edge that loads the result register, so a result
// passes through the input register and then the result register; one
// transaction can be taken in every cycle while out_ready stays high.
// Reset (synchronous, active low) empties both registers and marks every
// channel's number and value bytes as unknown; a clear-all does the same to
// the channel state.
// A stalled result holds the parser stage, and in_ready falls only when both
// the input register and the result register are full and out_ready is low.
//
module midi_parameter_number_parser_unit import mnpp_pkg::*; #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic        in_is_control_change,
  input  logic [3:0]  in_midi_channel,
  input  logic [6:0]  in_controller,
  input  logic [6:0]  in_data_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel,
  output logic [13:0] out_parameter_number,
  output logic [13:0] out_parameter_value,
  output logic        out_is_registered,
  output logic        out_is_fourteen_bit
);

  logic stage_valid;
  msg_t stage_msg;
  logic advance;
  logic fire;
  logic emit;
  res_t res;

  // The held transaction is applied when the result register can take its
  // outcome; a message that yields no result still waits for that slot so
  // that transactions leave in order.
  assign fire = stage_valid && advance;

  mnpp_in_stage u_in_stage (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_is_control_change (in_is_control_change),
    .in_midi_channel      (in_midi_channel),
    .in_controller        (in_controller),
    .in_data_value        (in_data_value),
    .advance              (advance),
    .valid                (stage_valid),
    .msg                  (stage_msg)
  );

  // The channel state is updated on the same edge that captures the result,
  // so back-to-back messages on one channel always see each other's effect.
  mnpp_chan_state #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_chan_state (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .msg   (stage_msg),
    .emit  (emit),
    .res   (res)
  );

  mnpp_out_stage u_out_stage (
    .clk                  (clk),
    .rst_n                (rst_n),
    .fire                 (fire),
    .emit                 (emit),
    .res                  (res),
    .advance              (advance),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_channel          (out_channel),
    .out_parameter_number (out_parameter_number),
    .out_parameter_value  (out_parameter_value),
    .out_is_registered    (out_is_registered),
    .out_is_fourteen_bit  (out_is_fourteen_bit)
  );

endmodule

@@ design/mnpp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker for the parameter number parser
// Watches the top-level ports and flags results that break the handshake or
// could not come from a correct parse.
// ----------------------------------------------------------------------------
module mnpp_checker #(
  parameter int CHANNEL_COUNT = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_channel,
  input logic [13:0] out_parameter_number,
  input logic [13:0] out_parameter_value,
  input logic        out_is_registered,
  input logic        out_is_fourteen_bit
);

  localparam logic [4:0] CH_LIMIT = 5'(CHANNEL_COUNT);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_channel) && $stable(out_parameter_number)
      && $stable(out_parameter_value) && $stable(out_is_registered)
      && $stable(out_is_fourteen_bit))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // Without a value low byte only the seven data bits can be set.
  a_seven_bit_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_fourteen_bit |-> out_parameter_value[13:7] == 7'd0)
    else $error("7-bit value carries high bits");

  // Messages on channels beyond the count are ignored.
  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_channel} < CH_LIMIT)
    else $error("result on a channel beyond the count");

endmodule

bind midi_parameter_number_parser_unit mnpp_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_mnpp_checker (.*);

@@ sim/midi_parameter_number_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parameter number checker
// Watches the message and result channels of the parameter number parser,
// keeps its own per-channel parser state and compares every completed
// parameter message with the one it assembled itself.
// ----------------------------------------------------------------------------
module midi_parameter_number_checker import mnpp_pkg::*; #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic        in_is_control_change,
  input  logic [3:0]  in_midi_channel,
  input  logic [6:0]  in_controller,
  input  logic [6:0]  in_data_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_channel,
  input  logic [13:0] out_parameter_number,
  input  logic [13:0] out_parameter_value,
  input  logic        out_is_registered,
  input  logic        out_is_fourteen_bit,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count
);

  // Per-channel parser state. The byte stores are only read while their
  // known flag is set, so they are left unset after reset.
  logic       number_hi_known [CHANNEL_COUNT];
  logic [6:0] number_hi       [CHANNEL_COUNT];
  logic       number_lo_known [CHANNEL_COUNT];
  logic [6:0] number_lo       [CHANNEL_COUNT];
  logic       registered      [CHANNEL_COUNT];
  logic       value_lo_known  [CHANNEL_COUNT];
  logic [6:0] value_lo        [CHANNEL_COUNT];

  res_t pending_params[$];
  int   mismatches = 0;
  int   compared = 0;

  task automatic forget_all_channels();
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      number_hi_known[c] = 1'b0;
      number_lo_known[c] = 1'b0;
      registered[c]      = 1'b0;
      value_lo_known[c]  = 1'b0;
    end
  endtask

  task automatic parse_message(msg_t m);
    res_t       param;
    logic [3:0] ch;
    ch = m.channel;
    if (m.op == OP_CLEAR) begin
      forget_all_channels();
      return;
    end
    if (!m.is_cc || ch >= CHANNEL_COUNT) return;
    case (m.controller)
      CC_NRPN_LSB, CC_RPN_LSB: begin
        number_lo[ch]       = m.data;
        number_lo_known[ch] = 1'b1;
        value_lo_known[ch]  = 1'b0;
        registered[ch]      = (m.controller == CC_RPN_LSB);
      end
      CC_NRPN_MSB, CC_RPN_MSB: begin
        number_hi[ch]       = m.data;
        number_hi_known[ch] = 1'b1;
        value_lo_known[ch]  = 1'b0;
        registered[ch]      = (m.controller == CC_RPN_MSB);
      end
      CC_DATA_LSB: begin
        value_lo[ch]       = m.data;
        value_lo_known[ch] = 1'b1;
      end
      CC_DATA_MSB: begin
        if (number_hi_known[ch] && number_lo_known[ch]) begin
          param.channel      = ch;
          param.number       = {number_hi[ch], number_lo[ch]};
          param.value        = value_lo_known[ch] ? {m.data, value_lo[ch]} : {7'd0, m.data};
          param.registered   = registered[ch];
          param.fourteen_bit = value_lo_known[ch];
          pending_params.push_back(param);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_param(res_t got);
    res_t want;
    compared++;
    if (pending_params.size() == 0) begin
      report_mismatch($sformatf("unexpected result, channel %0d number %0d value %0d",
                                got.channel, got.number, got.value));
      return;
    end
    want = pending_params.pop_front();
    if (got.channel != want.channel)
      report_mismatch($sformatf("channel %0d, expected %0d", got.channel, want.channel));
    if (got.number != want.number)
      report_mismatch($sformatf("parameter number %0d, expected %0d", got.number, want.number));
    if (got.value != want.value)
      report_mismatch($sformatf("parameter value %0d, expected %0d", got.value, want.value));
    if (got.registered != want.registered)
      report_mismatch($sformatf("registered flag %0b, expected %0b",
                                got.registered, want.registered));
    if (got.fourteen_bit != want.fourteen_bit)
      report_mismatch($sformatf("14-bit flag %0b, expected %0b",
                                got.fourteen_bit, want.fourteen_bit));
  endtask

  // Results are compared before the new message is applied: a result always
  // stems from a message accepted at an earlier edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      forget_all_channels();
      pending_params.delete();
    end else begin
      if (out_valid && out_ready)
        check_param('{out_channel, out_parameter_number, out_parameter_value,
                      out_is_registered, out_is_fourteen_bit});
      if (in_valid && in_ready)
        parse_message('{op_t'(in_operation), in_is_control_change, in_midi_channel,
                        in_controller, in_data_value});
    end
    fail_count    <= mismatches;
    pending_count <= pending_params.size();
    checked_count <= compared;
  end

endmodule

@@ sim/tb_midi_parameter_number_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parameter number parser testbench
// Feeds hand-picked and random control-change streams into the parser under
// four idling phases, while a separate checker predicts and compares every
// completed registered or non-registered parameter message.
// ----------------------------------------------------------------------------
module tb_midi_parameter_number_parser_unit import mnpp_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = 1'b0;
  logic        in_is_control_change = 1'b0;
  logic [3:0]  in_midi_channel = 4'd0;
  logic [6:0]  in_controller = 7'd0;
  logic [6:0]  in_data_value = 7'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_channel;
  logic [13:0] out_parameter_number;
  logic [13:0] out_parameter_value;
  logic        out_is_registered;
  logic        out_is_fourteen_bit;

  int fail_count;
  int pending_count;
  int checked_count;

  // Idling percentages. The sender's is only used by the stimulus process
  // itself; the receiver's is read by the stall process and is therefore only
  // ever changed with a nonblocking assignment.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // Transactions accepted, and the share of them that can act on parser state.
  int applied = 0;
  int effective = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  midi_parameter_number_parser_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_is_control_change (in_is_control_change),
    .in_midi_channel      (in_midi_channel),
    .in_controller        (in_controller),
    .in_data_value        (in_data_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_channel          (out_channel),
    .out_parameter_number (out_parameter_number),
    .out_parameter_value  (out_parameter_value),
    .out_is_registered    (out_is_registered),
    .out_is_fourteen_bit  (out_is_fourteen_bit)
  );

  midi_parameter_number_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_is_control_change (in_is_control_change),
    .in_midi_channel      (in_midi_channel),
    .in_controller        (in_controller),
    .in_data_value        (in_data_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_channel          (out_channel),
    .out_parameter_number (out_parameter_number),
    .out_parameter_value  (out_parameter_value),
    .out_is_registered    (out_is_registered),
    .out_is_fourteen_bit  (out_is_fourteen_bit),
    .fail_count           (fail_count),
    .pending_count        (pending_count),
    .checked_count        (checked_count)
  );

  // The receiver decides afresh at every edge whether to take a result, so
  // that stalls land on every stage of the parser's work.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Data bytes lean towards the extremes so that both ends of every 7-bit
  // field are seen often.
  function automatic logic [6:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Presents one transaction and holds it until the parser has taken it. An
  // idle gap, if any, comes before valid is raised, so valid never falls
  // while a transaction is waiting. A transaction that directly follows
  // another keeps valid high and only changes the payload.
  task automatic send_message(op_t op, logic cc, logic [3:0] ch, logic [6:0] ctl,
                              logic [6:0] data);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_operation         <= op;
    in_is_control_change <= cc;
    in_midi_channel      <= ch;
    in_controller        <= ctl;
    in_data_value        <= data;
    do @(posedge clk); while (!in_ready);
    applied++;
    if (op == OP_CLEAR ||
        (cc && ctl inside {CC_NRPN_LSB, CC_NRPN_MSB, CC_RPN_LSB, CC_RPN_MSB,
                           CC_DATA_LSB, CC_DATA_MSB}))
      effective++;
  endtask

  task automatic send_cc(logic [3:0] ch, logic [6:0] ctl, logic [6:0] data);
    send_message(OP_FEED, 1'b1, ch, ctl, data);
  endtask

  // Background traffic: any controller on any channel, some messages that
  // are not control changes, and the occasional clear-all. Half of the
  // controllers are drawn from the ones the parser reacts to, so that the
  // noise also breaks up sequences in progress.
  task automatic send_noise();
    logic [6:0] ctl;
    logic [6:0] known_ctl [6];
    known_ctl = '{CC_NRPN_LSB, CC_NRPN_MSB, CC_RPN_LSB, CC_RPN_MSB, CC_DATA_LSB, CC_DATA_MSB};
    if ($urandom_range(0, 1) == 0)
      ctl = 7'($urandom_range(0, 127));
    else
      ctl = known_ctl[$urandom_range(0, 5)];
    send_message(($urandom_range(0, 49) == 0) ? OP_CLEAR : OP_FEED,
                 ($urandom_range(0, 3) != 0), 4'($urandom_range(0, 15)), ctl,
                 random_byte());
  endtask

  // One parameter message as a sender would write it: the two number bytes
  // in either order, sometimes only one of them or a mix of registered and
  // non-registered, an optional value low byte, then one or more data
  // entries. Noise now and then lands in the middle of the sequence.
  task automatic send_parameter_sequence();
    logic [3:0] ch;
    logic       rpn;
    logic [6:0] lo_ctl;
    logic [6:0] hi_ctl;
    ch     = 4'($urandom_range(0, 15));
    rpn    = 1'($urandom_range(0, 1));
    lo_ctl = rpn ? CC_RPN_LSB : CC_NRPN_LSB;
    hi_ctl = rpn ? CC_RPN_MSB : CC_NRPN_MSB;
    case ($urandom_range(0, 5))
      0, 1: begin
        send_cc(ch, hi_ctl, random_byte());
        send_cc(ch, lo_ctl, random_byte());
      end
      2, 3: begin
        send_cc(ch, lo_ctl, random_byte());
        send_cc(ch, hi_ctl, random_byte());
      end
      4: begin
        send_cc(ch, ($urandom_range(0, 1) != 0) ? hi_ctl : lo_ctl, random_byte());
      end
      default: begin
        send_cc(ch, hi_ctl, random_byte());
        send_cc(ch, rpn ? CC_NRPN_LSB : CC_RPN_LSB, random_byte());
      end
    endcase
    if ($urandom_range(0, 1) != 0)
      send_cc(ch, CC_DATA_LSB, random_byte());
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0)
        send_noise();
      send_cc(ch, CC_DATA_MSB, random_byte());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with no idling on either side.
    // Clear-all with every other field at its top value: no result.
    send_message(OP_CLEAR, 1'b1, 4'd15, 7'd127, 7'd127);
    // Data entry before any number byte is known: no result.
    send_cc(4'd0, CC_DATA_MSB, 7'd5);
    send_cc(4'd0, CC_NRPN_MSB, 7'd127);
    // Only the high number byte is known yet: still no result.
    send_cc(4'd0, CC_DATA_MSB, 7'd9);
    send_cc(4'd0, CC_NRPN_LSB, 7'd127);
    // Largest non-registered number, 7-bit value.
    send_cc(4'd0, CC_DATA_MSB, 7'd127);
    // A value low byte turns the next data entries into 14-bit values, and
    // stays pending across them.
    send_cc(4'd0, CC_DATA_LSB, 7'd127);
    send_cc(4'd0, CC_DATA_MSB, 7'd0);
    send_cc(4'd0, CC_DATA_MSB, 7'd127);
    // A data entry that is not a control change, and an unrelated controller:
    // both are ignored.
    send_message(OP_FEED, 1'b0, 4'd0, CC_DATA_MSB, 7'd1);
    send_cc(4'd0, 7'd7, 7'd64);
    // Registered number zero with a zero value on the top channel.
    send_cc(4'd15, CC_RPN_MSB, 7'd0);
    send_cc(4'd15, CC_RPN_LSB, 7'd0);
    send_cc(4'd15, CC_DATA_LSB, 7'd0);
    send_cc(4'd15, CC_DATA_MSB, 7'd0);
    // A non-registered high byte takes over the registered mark and drops
    // the pending value low byte.
    send_cc(4'd15, CC_NRPN_MSB, 7'd5);
    send_cc(4'd15, CC_DATA_MSB, 7'd1);
    // A registered low byte drops a freshly stored value low byte as well.
    send_cc(4'd15, CC_DATA_LSB, 7'd3);
    send_cc(4'd15, CC_RPN_LSB, 7'd1);
    send_cc(4'd15, CC_DATA_MSB, 7'd2);
    // Channel 0 has kept its own state throughout.
    send_cc(4'd0, CC_DATA_MSB, 7'd1);
    // After a clear-all neither channel completes a message, not even once a
    // single number byte has been given again.
    send_message(OP_CLEAR, 1'b0, 4'd0, 7'd0, 7'd0);
    send_cc(4'd0, CC_DATA_MSB, 7'd4);
    send_cc(4'd15, CC_NRPN_LSB, 7'd1);
    send_cc(4'd15, CC_DATA_MSB, 7'd4);

    // Random part in four idling phases: none, sender idle, receiver
    // stalling, and both at once.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct = 74;
          receiver_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct <= 74;
        end
        default: begin
          sender_idle_pct = 30;
          receiver_stall_pct <= 30;
        end
      endcase
      while (effective < (phase + 1) * 188) begin
        if ($urandom_range(0, 4) == 0)
          send_noise();
        else
          send_parameter_sequence();
      end
    end
    in_valid <= 1'b0;

    // Let the checker's counters catch up with the last transaction, wait
    // for every expected result, then keep the clock running for anything
    // unexpected still in the pipeline.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d input transactions, %0d of them acting on parser state,",
             applied, effective);
    $display("over four idling phases, with %0d parameter results compared.",
             checked_count);
    if (fail_count == 0 && pending_count == 0)
      $display("midi_parameter_number_parser_unit verification clean");
    else
      $display("midi_parameter_number_parser_unit verification failed");
    $finish;
  end

  // A correct run needs well under a tenth of this time, even with the
  // heaviest idling.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected.", pending_count);
    $display("midi_parameter_number_parser_unit verification failed");
    $finish;
  end

endmodule
